FILE: rtl/core/gate_pose_estimator_top_macros.svh
// ---------------------------------------------------------------------------
// Gate pose estimator assertion macros
// Shared concurrent assertion forms for the estimator core.
// ---------------------------------------------------------------------------
`ifndef GATE_POSE_ESTIMATOR_TOP_MACROS_SVH
`define GATE_POSE_ESTIMATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GPE_ASSERT_IMP(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
        else $error("gate pose estimator: implication violated");

// Next-cycle implication, disabled during reset.
`define GPE_ASSERT_NXT(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
        else $error("gate pose estimator: next-cycle rule violated");

`endif

FILE: rtl/core/gpe_pkg.sv
// ---------------------------------------------------------------------------
// Gate pose estimator package
// Shared types, codes, constants and the CORDIC angle table.
// ---------------------------------------------------------------------------
`default_nettype none

package gpe_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FAIL  = 2'd1;
    localparam logic [1:0] STATUS_NOSEG = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_TAN_FOV_X     = 3'd2;
    localparam logic [2:0] REG_TAN_FOV_Y     = 3'd3;
    localparam logic [2:0] REG_REAL_WIDTH    = 3'd4;
    localparam logic [2:0] REG_REAL_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_EXPECT_ASPECT = 3'd6;

    // Iteration counts and the angle accumulator width of the back end.
    localparam int CORDIC_STEPS = 20;
    localparam int NUM_BITS     = 40;
    localparam int ZW           = 24;

    // Configuration register set.
    typedef struct packed {
        logic [11:0] image_width;
        logic [11:0] image_height;
        logic [15:0] tan_half_fov_x;
        logic [15:0] tan_half_fov_y;
        logic [15:0] target_real_width;
        logic [15:0] target_real_height;
        logic [15:0] expected_aspect;
    } cfg_t;

    // Arctangent of 2^-i in degrees, 16 fractional bits.
    function automatic logic [ZW-1:0] atan_q16(input logic [4:0] i);
        logic [ZW-1:0] v;
        begin
            case (i)
                5'd0:    v = 24'd2949120;
                5'd1:    v = 24'd1740967;
                5'd2:    v = 24'd919879;
                5'd3:    v = 24'd466945;
                5'd4:    v = 24'd234379;
                5'd5:    v = 24'd117304;
                5'd6:    v = 24'd58666;
                5'd7:    v = 24'd29335;
                5'd8:    v = 24'd14668;
                5'd9:    v = 24'd7334;
                5'd10:   v = 24'd3667;
                5'd11:   v = 24'd1833;
                5'd12:   v = 24'd917;
                5'd13:   v = 24'd458;
                5'd14:   v = 24'd229;
                5'd15:   v = 24'd115;
                5'd16:   v = 24'd57;
                5'd17:   v = 24'd29;
                5'd18:   v = 24'd14;
                5'd19:   v = 24'd7;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gpe_front.sv
// ---------------------------------------------------------------------------
// Gate pose estimator front end
// Accepts a segment word, finds the centroid and runs the sanity checks.
// ---------------------------------------------------------------------------
`default_nettype none

module gpe_front #(
    parameter int COORD_BITS = 12,
    parameter int PW         = 14,
    parameter int QW         = 44
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            segment_count,
    input  wire logic [COORD_BITS-1:0] seg0_x_a,
    input  wire logic [COORD_BITS-1:0] seg0_y_a,
    input  wire logic [COORD_BITS-1:0] seg0_x_b,
    input  wire logic [COORD_BITS-1:0] seg0_y_b,
    input  wire logic [COORD_BITS-1:0] seg1_x_a,
    input  wire logic [COORD_BITS-1:0] seg1_y_a,
    input  wire logic [COORD_BITS-1:0] seg1_x_b,
    input  wire logic [COORD_BITS-1:0] seg1_y_b,
    input  wire gpe_pkg::cfg_t         cfg,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output logic [QW-1:0]              push_data
);

    localparam int CB = COORD_BITS;
    localparam int VW = PW + 4;
    localparam int CW = CB + 22;

    logic          s_valid_reg;
    logic [1:0]    cnt_reg;
    logic [CB-1:0] x0a_reg, y0a_reg, x0b_reg, y0b_reg;
    logic [CB-1:0] x1a_reg, y1a_reg, x1b_reg, y1b_reg;

    logic [CB-1:0]  h0, w0, h1, w1, gw, gpw, gph, pix;
    logic [CB:0]    sx0, sx1, sy0, sy1, wsum, hsum, sxd;
    logic [CB+1:0]  sx4, sy4;
    logic signed [VW-1:0] vx1, vy1, vx2, vy2, tx1, ty1, tx2, ty2;
    logic signed [PW-1:0] px, py;
    logic [CB+15:0] prod_eg;
    logic           fail1, fail2;
    logic [1:0]     status;

    // Input stage: holds one word until the queue takes it.
    assign in_ready   = !s_valid_reg || push_ready;
    assign push_valid = s_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cnt_reg <= segment_count;
            x0a_reg <= seg0_x_a;
            y0a_reg <= seg0_y_a;
            x0b_reg <= seg0_x_b;
            y0b_reg <= seg0_y_b;
            x1a_reg <= seg1_x_a;
            y1a_reg <= seg1_y_a;
            x1b_reg <= seg1_x_b;
            y1b_reg <= seg1_y_b;
        end
    end

    // Segment sizes and endpoint sums.
    always_comb
    begin
        h0   = (y0a_reg > y0b_reg) ? y0a_reg - y0b_reg : y0b_reg - y0a_reg;
        w0   = (x0a_reg > x0b_reg) ? x0a_reg - x0b_reg : x0b_reg - x0a_reg;
        h1   = (y1a_reg > y1b_reg) ? y1a_reg - y1b_reg : y1b_reg - y1a_reg;
        w1   = (x1a_reg > x1b_reg) ? x1a_reg - x1b_reg : x1b_reg - x1a_reg;
        sx0  = {1'b0, x0a_reg} + {1'b0, x0b_reg};
        sx1  = {1'b0, x1a_reg} + {1'b0, x1b_reg};
        sy0  = {1'b0, y0a_reg} + {1'b0, y0b_reg};
        sy1  = {1'b0, y1a_reg} + {1'b0, y1b_reg};
        sx4  = {1'b0, sx0} + {1'b0, sx1};
        sy4  = {1'b0, sy0} + {1'b0, sy1};
        wsum = {1'b0, w0} + {1'b0, w1};
        hsum = {1'b0, h0} + {1'b0, h1};
        sxd  = (sx0 > sx1) ? sx0 - sx1 : sx1 - sx0;
        gw   = wsum[CB:1];
        gph  = hsum[CB:1];
        gpw  = sxd[CB:1];
    end

    // Centroid offsets, rounded toward zero.
    always_comb
    begin
        vx1 = $signed({{(VW-CB-1){1'b0}}, sx0}) - $signed({{(VW-12){1'b0}}, cfg.image_width});
        vy1 = $signed({{(VW-CB-1){1'b0}}, sy0}) - $signed({{(VW-12){1'b0}}, cfg.image_height});
        vx2 = $signed({{(VW-CB-2){1'b0}}, sx4})
            - $signed({{(VW-13){1'b0}}, cfg.image_width, 1'b0});
        vy2 = $signed({{(VW-CB-2){1'b0}}, sy4})
            - $signed({{(VW-13){1'b0}}, cfg.image_height, 1'b0});
        tx1 = vx1[VW-1] ? -((-vx1) >>> 1) : (vx1 >>> 1);
        ty1 = vy1[VW-1] ? -((-vy1) >>> 1) : (vy1 >>> 1);
        tx2 = vx2[VW-1] ? -((-vx2) >>> 2) : (vx2 >>> 2);
        ty2 = vy2[VW-1] ? -((-vy2) >>> 2) : (vy2 >>> 2);
    end

    // Sanity checks for one and for two segments.
    assign prod_eg = cfg.expected_aspect * gph;

    always_comb
    begin
        fail1 = (CW'(h0) * CW'(2)) < (CW'(w0) * CW'(19));
        fail2 = ((CW'(h0) * CW'(10)) > (CW'(h1) * CW'(13)))
             || ((CW'(h0) * CW'(13)) < (CW'(h1) * CW'(10)))
             || ((CW'(h0) * CW'(2)) < (CW'(gw) * CW'(19)))
             || ((CW'(gpw) * CW'(40960)) > (CW'(prod_eg) * CW'(13)))
             || ((CW'(gpw) * CW'(53248)) < (CW'(prod_eg) * CW'(10)));
    end

    // Classify and pack the queue word.
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                status = gpe_pkg::STATUS_NOSEG;
                px     = tx1[PW-1:0];
                py     = ty1[PW-1:0];
                pix    = h0;
            end
            2'd1:
            begin
                status = fail1 ? gpe_pkg::STATUS_FAIL : gpe_pkg::STATUS_OK;
                px     = tx1[PW-1:0];
                py     = ty1[PW-1:0];
                pix    = h0;
            end
            default:
            begin
                status = fail2 ? gpe_pkg::STATUS_FAIL : gpe_pkg::STATUS_OK;
                px     = tx2[PW-1:0];
                py     = ty2[PW-1:0];
                pix    = gpw;
            end
        endcase
        push_data = {status, cnt_reg[1], pix, px, py};
    end

endmodule

`default_nettype wire

FILE: rtl/core/gpe_queue.sv
// ---------------------------------------------------------------------------
// Gate pose estimator queue
// Small FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module gpe_queue #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNTW'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/gpe_back.sv
// ---------------------------------------------------------------------------
// Gate pose estimator back end
// Runs the range divider and two CORDIC bearings, then holds the result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "gate_pose_estimator_top_macros.svh"

module gpe_back #(
    parameter int COORD_BITS      = 12,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int PW              = 14,
    parameter int QW              = 44
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire gpe_pkg::cfg_t cfg,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire logic [QW-1:0] pop_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [1:0]         status,
    output logic               range_valid,
    output logic [15:0]        range_estimate,
    output logic               angles_valid,
    output logic signed [15:0] angle_x,
    output logic signed [15:0] angle_y
);

    localparam int CB = COORD_BITS;
    localparam int XW = PW + 34;
    localparam int DW = CB + 16;
    localparam int NW = gpe_pkg::NUM_BITS;
    localparam int ZW = gpe_pkg::ZW;
    localparam int AF = ANGLE_FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] step_reg;

    logic [1:0]           st_reg;
    logic                 use_x_reg;
    logic [CB-1:0]        pix_reg;
    logic signed [PW-1:0] px_reg, py_reg;
    logic                 zx_reg, zy_reg;

    logic signed [XW-1:0] xx_reg, yx_reg, xy_reg, yy_reg;
    logic signed [ZW-1:0] zx_acc_reg, zy_acc_reg;
    logic [NW-1:0]        num_reg, q_reg;
    logic [DW-1:0]        den_reg, rem_reg;

    logic [1:0]           q_status;
    logic                 q_use_x;
    logic [CB-1:0]        q_pix;
    logic signed [PW-1:0] q_px, q_py;
    logic signed [PW-1:0] neg_x, neg_y;
    logic [PW-2:0]        mag_x, mag_y;
    logic [PW+14:0]       ty_x, ty_y;
    logic [27:0]          nw_prod, nh_prod;
    logic [DW:0]          trial;
    logic [4:0]           ci;
    logic [ZW-1:0]        atan_v;
    logic                 out_free;
    logic [15:0]          range_q;

    assign {q_status, q_use_x, q_pix, q_px, q_py} = pop_data;
    assign pop_ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid || out_ready;
    assign ci        = step_reg[4:0];
    assign atan_v    = gpe_pkg::atan_q16(ci);

    // Magnitudes of the held centroid offsets.
    assign neg_x = -px_reg;
    assign neg_y = -py_reg;
    assign mag_x = px_reg[PW-1] ? neg_x[PW-2:0] : px_reg[PW-2:0];
    assign mag_y = py_reg[PW-1] ? neg_y[PW-2:0] : py_reg[PW-2:0];

    // Full-width products for the CORDIC start value and the dividend.
    assign ty_x    = cfg.tan_half_fov_x * mag_x;
    assign ty_y    = cfg.tan_half_fov_y * mag_y;
    assign nw_prod = cfg.target_real_width * cfg.image_width;
    assign nh_prod = cfg.target_real_height * cfg.image_height;

    // Divider trial subtraction.
    assign trial = {rem_reg, num_reg[NW-1]} - {1'b0, den_reg};

    // Final bearing: clamp, round half up, cap, sign.
    function automatic logic [15:0] finish_angle(input logic signed [ZW-1:0] z,
                                                 input logic neg,
                                                 input logic zero);
        logic [ZW:0]   zr;
        logic [ZW:0]   r;
        logic [15:0]   m;
        begin
            zr = z[ZW-1] ? '0 : ({1'b0, z} + ((ZW+1)'(1) << (15 - AF)));
            r  = zr >> (16 - AF);
            m  = (r > (ZW+1)'(32767)) ? 16'd32767 : r[15:0];
            if (zero)
            begin
                m = '0;
            end
            return neg ? (16'd0 - m) : m;
        end
    endfunction

    assign range_q = (den_reg == '0 || q_reg[NW-1:16] != '0) ? 16'hFFFF : q_reg[15:0];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (pop_valid) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_RUN;
            ST_RUN:  if (step_reg == 6'(NW - 1)) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_RUN)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // Datapath: load, iterate, and hold the result word.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    st_reg    <= q_status;
                    use_x_reg <= q_use_x;
                    pix_reg   <= q_pix;
                    px_reg    <= q_px;
                    py_reg    <= q_py;
                end
            end
            ST_LOAD:
            begin
                xx_reg     <= XW'({cfg.image_width, 28'd0});
                xy_reg     <= XW'({cfg.image_height, 28'd0});
                yx_reg     <= XW'({ty_x, 16'd0});
                yy_reg     <= XW'({ty_y, 16'd0});
                zx_acc_reg <= '0;
                zy_acc_reg <= '0;
                zx_reg     <= (px_reg == '0) || (cfg.tan_half_fov_x == '0);
                zy_reg     <= (py_reg == '0) || (cfg.tan_half_fov_y == '0);
                num_reg    <= use_x_reg ? NW'({nw_prod, 12'd0})
                                        : NW'({nh_prod, 12'd0});
                den_reg    <= use_x_reg ? pix_reg * cfg.tan_half_fov_x
                                        : pix_reg * cfg.tan_half_fov_y;
                rem_reg    <= '0;
                q_reg      <= '0;
            end
            ST_RUN:
            begin
                // One restoring division step per cycle.
                if (!trial[DW])
                begin
                    rem_reg <= trial[DW-1:0];
                end
                else
                begin
                    rem_reg <= {rem_reg[DW-2:0], num_reg[NW-1]};
                end
                q_reg   <= {q_reg[NW-2:0], !trial[DW]};
                num_reg <= {num_reg[NW-2:0], 1'b0};
                // CORDIC vectoring steps for both axes.
                if (step_reg < 6'(gpe_pkg::CORDIC_STEPS))
                begin
                    if (!yx_reg[XW-1])
                    begin
                        xx_reg     <= xx_reg + (yx_reg >>> ci);
                        yx_reg     <= yx_reg - (xx_reg >>> ci);
                        zx_acc_reg <= zx_acc_reg + $signed(atan_v);
                    end
                    else
                    begin
                        xx_reg     <= xx_reg - (yx_reg >>> ci);
                        yx_reg     <= yx_reg + (xx_reg >>> ci);
                        zx_acc_reg <= zx_acc_reg - $signed(atan_v);
                    end
                    if (!yy_reg[XW-1])
                    begin
                        xy_reg     <= xy_reg + (yy_reg >>> ci);
                        yy_reg     <= yy_reg - (xy_reg >>> ci);
                        zy_acc_reg <= zy_acc_reg + $signed(atan_v);
                    end
                    else
                    begin
                        xy_reg     <= xy_reg - (yy_reg >>> ci);
                        yy_reg     <= yy_reg + (xy_reg >>> ci);
                        zy_acc_reg <= zy_acc_reg - $signed(atan_v);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    status <= st_reg;
                    if (st_reg == gpe_pkg::STATUS_NOSEG)
                    begin
                        range_valid    <= 1'b0;
                        range_estimate <= '0;
                        angles_valid   <= 1'b0;
                        angle_x        <= '0;
                        angle_y        <= '0;
                    end
                    else
                    begin
                        range_valid    <= (st_reg == gpe_pkg::STATUS_OK);
                        range_estimate <= (st_reg == gpe_pkg::STATUS_OK) ? range_q : '0;
                        angles_valid   <= 1'b1;
                        angle_x <= $signed(finish_angle(zx_acc_reg, px_reg[PW-1], zx_reg));
                        angle_y <= $signed(finish_angle(zy_acc_reg, py_reg[PW-1], zy_reg));
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // A word leaves the queue only into an idle back end.
    `GPE_ASSERT_IMP(a_pop_idle, clk, rst_n, pop_valid && pop_ready, state_reg == ST_IDLE)
    // The last division step hands over to result delivery.
    `GPE_ASSERT_NXT(a_run_done, clk, rst_n,
        state_reg == ST_RUN && step_reg == 6'(NW - 1), state_reg == ST_DONE)
    // A finished result waits while the output register is still occupied.
    `GPE_ASSERT_NXT(a_done_hold, clk, rst_n,
        state_reg == ST_DONE && out_valid && !out_ready, state_reg == ST_DONE)

endmodule

`default_nettype wire

FILE: rtl/core/gate_pose_estimator_top.sv
// ---------------------------------------------------------------------------
// Gate pose estimator top level
// Bearing and range to a gate from zero, one or two line segments.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_ready     segment_count, seg0_*, seg1_*
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//   out      out_valid / out_ready   status, range_*, angles_valid, angle_*
//
// In the back end each word is taken from the queue, loaded, run through 40
// restoring division steps (the CORDIC bearings run in the first 20 of them)
// and delivered; the back end takes no new word until it has delivered the
// last one.
// The front end and a two-word queue keep accepting while the back end works.
// Reset loads the register defaults and empties the queue; no clearing pass.
// A stalled output holds the back end in delivery; upstream stalls only idle it.
// ---------------------------------------------------------------------------
`default_nettype none

module gate_pose_estimator_top #(
    parameter int COORD_BITS      = 12,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            segment_count,
    input  wire logic [COORD_BITS-1:0] seg0_x_a,
    input  wire logic [COORD_BITS-1:0] seg0_y_a,
    input  wire logic [COORD_BITS-1:0] seg0_x_b,
    input  wire logic [COORD_BITS-1:0] seg0_y_b,
    input  wire logic [COORD_BITS-1:0] seg1_x_a,
    input  wire logic [COORD_BITS-1:0] seg1_y_a,
    input  wire logic [COORD_BITS-1:0] seg1_x_b,
    input  wire logic [COORD_BITS-1:0] seg1_y_b,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [15:0]           cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 status,
    output logic                       range_valid,
    output logic [15:0]                range_estimate,
    output logic                       angles_valid,
    output logic signed [15:0]         angle_x,
    output logic signed [15:0]         angle_y
);

    localparam int PW = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
    localparam int QW = 3 + COORD_BITS + 2 * PW;

    gpe_pkg::cfg_t   cfg_reg;
    logic            push_valid, push_ready, pop_valid, pop_ready;
    logic [QW-1:0]   push_data, pop_data;

    // Configuration registers, always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width        <= 12'd640;
            cfg_reg.image_height       <= 12'd480;
            cfg_reg.tan_half_fov_x     <= 16'd3072;
            cfg_reg.tan_half_fov_y     <= 16'd2304;
            cfg_reg.target_real_width  <= 16'd300;
            cfg_reg.target_real_height <= 16'd120;
            cfg_reg.expected_aspect    <= 16'd10240;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gpe_pkg::REG_IMAGE_WIDTH:   cfg_reg.image_width        <= cfg_data[11:0];
                gpe_pkg::REG_IMAGE_HEIGHT:  cfg_reg.image_height       <= cfg_data[11:0];
                gpe_pkg::REG_TAN_FOV_X:     cfg_reg.tan_half_fov_x     <= cfg_data;
                gpe_pkg::REG_TAN_FOV_Y:     cfg_reg.tan_half_fov_y     <= cfg_data;
                gpe_pkg::REG_REAL_WIDTH:    cfg_reg.target_real_width  <= cfg_data;
                gpe_pkg::REG_REAL_HEIGHT:   cfg_reg.target_real_height <= cfg_data;
                gpe_pkg::REG_EXPECT_ASPECT: cfg_reg.expected_aspect    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front end: accept and classify.
    gpe_front #(
        .COORD_BITS (COORD_BITS),
        .PW         (PW),
        .QW         (QW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .segment_count (segment_count),
        .seg0_x_a      (seg0_x_a),
        .seg0_y_a      (seg0_y_a),
        .seg0_x_b      (seg0_x_b),
        .seg0_y_b      (seg0_y_b),
        .seg1_x_a      (seg1_x_a),
        .seg1_y_a      (seg1_y_a),
        .seg1_x_b      (seg1_x_b),
        .seg1_y_b      (seg1_y_b),
        .cfg           (cfg_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    // Queue between the two halves.
    gpe_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back end: range and bearings.
    gpe_back #(
        .COORD_BITS      (COORD_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .PW              (PW),
        .QW              (QW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_data       (pop_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .range_valid    (range_valid),
        .range_estimate (range_estimate),
        .angles_valid   (angles_valid),
        .angle_x        (angle_x),
        .angle_y        (angle_y)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Gate pose estimator testbench
// Drives segment words through the estimator under random idling on both
// sides and compares every result word against a bit-exact predictor. The
// predictor covers the centroid, the CORDIC bearings, the sanity checks and
// the range. Several register settings are used, the extremes among them.
// ---------------------------------------------------------------------------

// One input word: segment count and eight coordinates in the order
// x0a, y0a, x0b, y0b, x1a, y1a, x1b, y1b.
typedef struct {
    logic [1:0]  count;
    logic [11:0] c [8];
} seg_word_t;

// One result word.
typedef struct {
    logic [1:0]         status;
    logic               range_valid;
    logic [15:0]        range_estimate;
    logic               angles_valid;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
} pose_word_t;

class pose_scoreboard;
    longint img_w, img_h, tan_x, tan_y, real_w, real_h, aspect;
    pose_word_t pending_poses[$];
    int errors;
    int seen_ok, seen_fail, seen_noseg;

    function new();
        img_w = 640; img_h = 480; tan_x = 3072; tan_y = 2304;
        real_w = 300; real_h = 120; aspect = 10240;
        errors = 0; seen_ok = 0; seen_fail = 0; seen_noseg = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            gpe_pkg::REG_IMAGE_WIDTH:   img_w  = val[11:0];
            gpe_pkg::REG_IMAGE_HEIGHT:  img_h  = val[11:0];
            gpe_pkg::REG_TAN_FOV_X:     tan_x  = val;
            gpe_pkg::REG_TAN_FOV_Y:     tan_y  = val;
            gpe_pkg::REG_REAL_WIDTH:    real_w = val;
            gpe_pkg::REG_REAL_HEIGHT:   real_h = val;
            gpe_pkg::REG_EXPECT_ASPECT: aspect = val;
            default: ;
        endcase
    endfunction

    static function longint absd(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Arctangent of the pixel offset in degrees, Q16 CORDIC then rounded to Q8.
    static function longint bearing(longint size, longint tanq, longint p);
        longint atan_tab [20] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                  58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                  229, 115, 57, 29, 14, 7};
        longint mag, x, y, z, dx, dy, r;
        if (p == 0 || tanq == 0)
            return 0;
        mag = (p < 0) ? -p : p;
        x = size << 28;
        y = (tanq * mag) << 16;
        z = 0;
        for (int i = 0; i < 20; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atan_tab[i];
            end
            else
            begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        if (z < 0)
            z = 0;
        r = (z + 128) >> 8;
        if (r > 32767)
            r = 32767;
        return (p < 0) ? -r : r;
    endfunction

    static function longint range_calc(longint rl, longint size, longint pix, longint tanq);
        longint den, q;
        den = pix * tanq;
        if (den == 0)
            return 65535;
        q = (rl * size * 4096) / den;
        return (q > 65535) ? 65535 : q;
    endfunction

    // Expected result for one accepted segment word.
    function pose_word_t estimate_pose(seg_word_t w);
        pose_word_t r;
        longint x0a, y0a, x0b, y0b, x1a, y1a, x1b, y1b;
        longint h, wd, h0, h1, gw, gpw, gph, px, py;
        bit fail;
        x0a = w.c[0]; y0a = w.c[1]; x0b = w.c[2]; y0b = w.c[3];
        x1a = w.c[4]; y1a = w.c[5]; x1b = w.c[6]; y1b = w.c[7];
        r.status = gpe_pkg::STATUS_NOSEG; r.range_valid = 0; r.range_estimate = 0;
        r.angles_valid = 0; r.angle_x = 0; r.angle_y = 0;
        if (w.count == 0)
            return r;
        if (w.count == 1)
        begin
            h = absd(y0a, y0b);
            wd = absd(x0a, x0b);
            px = (x0a + x0b - img_w) / 2;
            py = (y0a + y0b - img_h) / 2;
            fail = (2 * h < 19 * wd);
            if (!fail)
                r.range_estimate = range_calc(real_h, img_h, h, tan_y);
        end
        else
        begin
            // A count of three is handled as two segments.
            h0 = absd(y0a, y0b);
            h1 = absd(y1a, y1b);
            gw = (absd(x0a, x0b) + absd(x1a, x1b)) / 2;
            gpw = absd(x0a + x0b, x1a + x1b) / 2;
            gph = (h0 + h1) / 2;
            px = (x0a + x0b + x1a + x1b - 2 * img_w) / 4;
            py = (y0a + y0b + y1a + y1b - 2 * img_h) / 4;
            fail = (10 * h0 > 13 * h1) || (13 * h0 < 10 * h1) || (2 * h0 < 19 * gw) ||
                   (40960 * gpw > 13 * aspect * gph) || (53248 * gpw < 10 * aspect * gph);
            if (!fail)
                r.range_estimate = range_calc(real_w, img_w, gpw, tan_x);
        end
        r.status = fail ? gpe_pkg::STATUS_FAIL : gpe_pkg::STATUS_OK;
        r.range_valid = !fail;
        r.angles_valid = 1;
        r.angle_x = 16'(bearing(img_w, tan_x, px));
        r.angle_y = 16'(bearing(img_h, tan_y, py));
        return r;
    endfunction

    function void note_segments(seg_word_t w);
        pending_poses.push_back(estimate_pose(w));
    endfunction

    function void check_pose(pose_word_t got);
        pose_word_t exp_p;
        if (pending_poses.size() == 0)
        begin
            $display("%0t: result word with none expected (status %0d)", $time, got.status);
            errors++;
            return;
        end
        exp_p = pending_poses.pop_front();
        case (exp_p.status)
            gpe_pkg::STATUS_OK:   seen_ok++;
            gpe_pkg::STATUS_FAIL: seen_fail++;
            default:              seen_noseg++;
        endcase
        if (got.status !== exp_p.status)
        begin
            $display("%0t: status expected %0d got %0d", $time, exp_p.status, got.status);
            errors++;
        end
        if (got.range_valid !== exp_p.range_valid)
        begin
            $display("%0t: range_valid expected %0d got %0d", $time,
                     exp_p.range_valid, got.range_valid);
            errors++;
        end
        if (got.range_estimate !== exp_p.range_estimate)
        begin
            $display("%0t: range_estimate expected %0d got %0d", $time,
                     exp_p.range_estimate, got.range_estimate);
            errors++;
        end
        if (got.angles_valid !== exp_p.angles_valid)
        begin
            $display("%0t: angles_valid expected %0d got %0d", $time,
                     exp_p.angles_valid, got.angles_valid);
            errors++;
        end
        if (got.angle_x !== exp_p.angle_x)
        begin
            $display("%0t: angle_x expected %0d got %0d", $time, exp_p.angle_x, got.angle_x);
            errors++;
        end
        if (got.angle_y !== exp_p.angle_y)
        begin
            $display("%0t: angle_y expected %0d got %0d", $time, exp_p.angle_y, got.angle_y);
            errors++;
        end
    endfunction
endclass

module tb_top;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         segment_count;
    logic [11:0]        seg0_x_a, seg0_y_a, seg0_x_b, seg0_y_b;
    logic [11:0]        seg1_x_a, seg1_y_a, seg1_x_b, seg1_y_b;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic               range_valid;
    logic [15:0]        range_estimate;
    logic               angles_valid;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;

    pose_scoreboard sb;
    bit             no_idle;
    int             hold_req;
    int             phases_run;

    gate_pose_estimator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .segment_count  (segment_count),
        .seg0_x_a       (seg0_x_a),
        .seg0_y_a       (seg0_y_a),
        .seg0_x_b       (seg0_x_b),
        .seg0_y_b       (seg0_y_b),
        .seg1_x_a       (seg1_x_a),
        .seg1_y_a       (seg1_y_a),
        .seg1_x_b       (seg1_x_b),
        .seg1_y_b       (seg1_y_b),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .range_valid    (range_valid),
        .range_estimate (range_estimate),
        .angles_valid   (angles_valid),
        .angle_x        (angle_x),
        .angle_y        (angle_y)
    );

    // Clock, 10 ns period.
    initial
    begin
        clk = 0;
    end

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Hard limit on run length.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Record each accepted segment word and check each accepted result word.
    always @(posedge clk)
    begin
        seg_word_t  w;
        pose_word_t p;
        if (rst_n && in_valid && in_ready)
        begin
            w.count = segment_count;
            w.c[0] = seg0_x_a; w.c[1] = seg0_y_a; w.c[2] = seg0_x_b; w.c[3] = seg0_y_b;
            w.c[4] = seg1_x_a; w.c[5] = seg1_y_a; w.c[6] = seg1_x_b; w.c[7] = seg1_y_b;
            sb.note_segments(w);
        end
        if (rst_n && out_valid && out_ready)
        begin
            p.status = status; p.range_valid = range_valid;
            p.range_estimate = range_estimate; p.angles_valid = angles_valid;
            p.angle_x = angle_x; p.angle_y = angle_y;
            sb.check_pose(p);
        end
    end

    // Result receiver: random stalls per word, plus an occasional long hold-off.
    initial
    begin
        int n;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req > 0)
            begin
                n = hold_req;
                hold_req = 0;
                @(negedge clk) out_ready <= 0;
                repeat (n) @(negedge clk);
            end
            n = no_idle ? 0 : $urandom_range(0, 3);
            if (n > 0)
            begin
                @(negedge clk) out_ready <= 0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk) out_ready <= 1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk) cfg_valid <= 0;
    endtask

    task automatic write_all(logic [15:0] w, logic [15:0] h, logic [15:0] tx,
                             logic [15:0] ty, logic [15:0] rw, logic [15:0] rh,
                             logic [15:0] asp);
        write_reg(gpe_pkg::REG_IMAGE_WIDTH, w);
        write_reg(gpe_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(gpe_pkg::REG_TAN_FOV_X, tx);
        write_reg(gpe_pkg::REG_TAN_FOV_Y, ty);
        write_reg(gpe_pkg::REG_REAL_WIDTH, rw);
        write_reg(gpe_pkg::REG_REAL_HEIGHT, rh);
        write_reg(gpe_pkg::REG_EXPECT_ASPECT, asp);
        phases_run++;
    endtask

    // Offer one segment word after a random gap and wait for it to be taken.
    task automatic send_segments(seg_word_t w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            @(negedge clk) in_valid <= 0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1;
        segment_count <= w.count;
        seg0_x_a <= w.c[0]; seg0_y_a <= w.c[1]; seg0_x_b <= w.c[2]; seg0_y_b <= w.c[3];
        seg1_x_a <= w.c[4]; seg1_y_a <= w.c[5]; seg1_x_b <= w.c[6]; seg1_y_b <= w.c[7];
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_direct(logic [1:0] cnt, int x0a, int y0a, int x0b, int y0b,
                               int x1a, int y1a, int x1b, int y1b);
        seg_word_t w;
        w.count = cnt;
        w.c[0] = x0a; w.c[1] = y0a; w.c[2] = x0b; w.c[3] = y0b;
        w.c[4] = x1a; w.c[5] = y1a; w.c[6] = x1b; w.c[7] = y1b;
        send_segments(w);
    endtask

    // Random word: mostly plausible gates for the current aspect, some noise.
    function automatic seg_word_t random_segments();
        seg_word_t w;
        int    kind, h0, h1, w0, w1, xl, yt, gpw;
        longint lim;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 8; i++)
            w.c[i] = $urandom_range(0, 4095);
        w.count = $urandom_range(0, 3);
        if (kind == 0)
            return w;
        h0 = $urandom_range(1, 1500);
        w0 = $urandom_range(0, h0 / 9);
        yt = $urandom_range(0, 4095 - h0);
        if (kind <= 3)
        begin
            w.count = 1;
            xl = $urandom_range(0, 4095 - w0);
            w.c[0] = xl; w.c[2] = xl + w0;
            w.c[1] = yt; w.c[3] = yt + h0;
        end
        else
        begin
            w.count = 2;
            h0 = $urandom_range(10, 1500);
            h1 = h0 - h0 / 6 + $urandom_range(0, h0 / 3);
            w0 = $urandom_range(0, h0 / 12);
            w1 = $urandom_range(0, h0 / 12);
            lim = (sb.aspect * ((h0 + h1) / 2)) >> 12;
            lim = lim - lim / 8 + $urandom_range(0, 32'(lim / 4));
            gpw = (lim > 3800) ? 3800 : int'(lim);
            xl = $urandom_range(0, 4095 - gpw - w0 - w1 - 1);
            w.c[0] = xl; w.c[2] = xl + w0;
            w.c[4] = xl + gpw; w.c[6] = xl + gpw + w1;
            yt = $urandom_range(0, 4095 - ((h0 > h1) ? h0 : h1));
            w.c[1] = yt; w.c[3] = yt + h0;
            w.c[5] = yt + $urandom_range(0, 3); w.c[7] = w.c[5] + h1;
        end
        // Endpoint order is free.
        if ($urandom_range(0, 1))
        begin
            {w.c[0], w.c[2]} = {w.c[2], w.c[0]};
            {w.c[1], w.c[3]} = {w.c[3], w.c[1]};
        end
        if ($urandom_range(0, 1))
        begin
            {w.c[4], w.c[6]} = {w.c[6], w.c[4]};
            {w.c[5], w.c[7]} = {w.c[7], w.c[5]};
        end
        return w;
    endfunction

    task automatic run_random(int n, bit with_hold);
        for (int i = 0; i < n; i++)
        begin
            if (with_hold && i == n / 3)
                hold_req = 400;
            if (i % 100 == 50)
                no_idle = !no_idle;
            send_segments(random_segments());
        end
        @(negedge clk) in_valid <= 0;
        no_idle = 0;
    endtask

    // Wait for every expected word, then let the back end settle.
    task automatic drain();
        while (sb.pending_poses.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        no_idle = 0;
        hold_req = 0;
        phases_run = 0;
        rst_n = 0;
        in_valid = 0;
        segment_count = 0;
        {seg0_x_a, seg0_y_a, seg0_x_b, seg0_y_b} = '0;
        {seg1_x_a, seg1_y_a, seg1_x_b, seg1_y_b} = '0;
        cfg_valid = 0;
        cfg_index = gpe_pkg::REG_IMAGE_WIDTH;
        cfg_data = 0;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1;

        // Directed words under the reset defaults.
        send_direct(0, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
        send_direct(1, 0, 0, 0, 0, 0, 0, 0, 0);                  // zero height
        send_direct(1, 320, 100, 320, 380, 0, 0, 0, 0);          // centered x
        send_direct(1, 320, 240, 320, 240, 0, 0, 0, 0);          // dead center
        send_direct(1, 0, 0, 0, 4095, 0, 0, 0, 0);               // far left
        send_direct(1, 4095, 0, 4095, 4095, 0, 0, 0, 0);         // far right
        send_direct(1, 100, 200, 300, 210, 0, 0, 0, 0);          // not vertical
        send_direct(1, 500, 300, 500, 301, 0, 0, 0, 0);          // range saturates
        send_direct(2, 200, 100, 200, 300, 700, 100, 700, 300);  // good gate
        send_direct(3, 200, 100, 200, 300, 700, 100, 700, 300);  // count three
        send_direct(2, 200, 100, 200, 300, 700, 100, 700, 140);  // heights differ
        send_direct(2, 200, 100, 200, 140, 700, 100, 700, 300);  // heights differ
        send_direct(2, 200, 100, 260, 300, 700, 100, 760, 300);  // too wide
        send_direct(2, 200, 100, 200, 300, 1500, 100, 1500, 300);// aspect high
        send_direct(2, 200, 100, 200, 300, 260, 100, 260, 300);  // aspect low
        send_direct(2, 200, 100, 200, 100, 200, 100, 200, 100);  // all degenerate
        send_direct(2, 4095, 4095, 4095, 0, 0, 4095, 0, 0);
        send_direct(2, 0, 0, 0, 0, 4095, 4095, 4095, 4095);
        @(negedge clk) in_valid <= 0;
        run_random(400, 1);
        drain();

        // Smallest register values.
        write_all(1, 1, 1, 1, 1, 1, 1);
        run_random(300, 0);
        drain();

        // Largest register values.
        write_all(4095, 4095, 65535, 65535, 65535, 65535, 65535);
        send_direct(1, 0, 0, 0, 4095, 0, 0, 0, 0);
        send_direct(1, 4095, 4095, 4095, 4095, 0, 0, 0, 0);
        @(negedge clk) in_valid <= 0;
        run_random(300, 0);
        drain();

        // Random settings.
        repeat (2)
        begin
            write_all($urandom_range(1, 4095), $urandom_range(1, 4095),
                      $urandom_range(1, 65535), $urandom_range(1, 65535),
                      $urandom_range(1, 65535), $urandom_range(1, 65535),
                      $urandom_range(1, 65535));
            run_random(250, 0);
            drain();
        end

        // A camera-like setting to close out.
        write_all(1280, 960, $urandom_range(2000, 6000), $urandom_range(1500, 5000),
                  $urandom_range(100, 1000), $urandom_range(50, 500),
                  $urandom_range(4096, 16384));
        run_random(500, 1);
        drain();

        $display("Covered %0d register settings after reset: %0d estimates, %0d rejected,",
                 phases_run, sb.seen_ok, sb.seen_fail);
        $display("%0d no-target words, with random idling and a long output hold-off.",
                 sb.seen_noseg);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
